// ----- rtl/tws_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_pkg
// Shared types, constants and helpers of the wrap/scale texture sampler.
// ----------------------------------------------------------------------------
package tws_pkg;

  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;
  localparam int DEF_COORD_BITS = 12;

  localparam int POS_BITS   = 12;
  localparam int COLOR_BITS = 8;
  localparam int TEXEL_BITS = 4 * COLOR_BITS;
  localparam int SIZE_BITS  = 7;
  localparam int SCALE_BITS = 13;
  localparam int STEP_BITS  = 16;
  localparam int FRAC_BITS  = 8;
  localparam int SHIFT_BITS = 12;
  localparam int PROD_BITS  = SCALE_BITS + STEP_BITS;

  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_ADDR_BITS = 5;
  localparam int REG_IDX_BITS  = CFG_ADDR_BITS - 2;

  localparam logic [REG_IDX_BITS-1:0] REG_TEXTURE_WIDTH  = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_TEXTURE_HEIGHT = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_SCALED_WIDTH   = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_SCALED_HEIGHT  = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_STEP_X         = 3'd4;
  localparam logic [REG_IDX_BITS-1:0] REG_STEP_Y         = 3'd5;
  localparam logic [REG_IDX_BITS-1:0] REG_SHIFT_X        = 3'd6;
  localparam logic [REG_IDX_BITS-1:0] REG_SHIFT_Y        = 3'd7;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef struct packed {
    logic                  operation;
    logic [POS_BITS-1:0]   pos_x;
    logic [POS_BITS-1:0]   pos_y;
    logic [COLOR_BITS-1:0] red_in;
    logic [COLOR_BITS-1:0] green_in;
    logic [COLOR_BITS-1:0] blue_in;
    logic [COLOR_BITS-1:0] alpha_in;
  } tws_in_t;

  typedef struct packed {
    logic [POS_BITS-1:0]   pixel_x;
    logic [POS_BITS-1:0]   pixel_y;
    logic [COLOR_BITS-1:0] red_out;
    logic [COLOR_BITS-1:0] green_out;
    logic [COLOR_BITS-1:0] blue_out;
    logic [COLOR_BITS-1:0] alpha_out;
  } tws_out_t;

  typedef struct packed {
    logic [SIZE_BITS-1:0]         texture_width;
    logic [SIZE_BITS-1:0]         texture_height;
    logic [SCALE_BITS-1:0]        scaled_width;
    logic [SCALE_BITS-1:0]        scaled_height;
    logic [STEP_BITS-1:0]         step_x;
    logic [STEP_BITS-1:0]         step_y;
    logic signed [SHIFT_BITS-1:0] shift_x;
    logic signed [SHIFT_BITS-1:0] shift_y;
  } tws_cfg_t;

  // index width for n entries, at least one bit
  function automatic int tws_idx_bits(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  // magnitude bits of (pos - shift) after masking pos to coord_bits
  function automatic int tws_mag_bits(input int coord_bits);
    int cw;
    cw = (coord_bits < POS_BITS) ? coord_bits : POS_BITS;
    return ((cw > SHIFT_BITS - 1) ? cw : SHIFT_BITS - 1) + 1;
  endfunction

  // abs stage, one stage per remainder bit, fixup, multiply, clamp
  function automatic int tws_axis_latency(input int coord_bits);
    return tws_mag_bits(coord_bits) + 4;
  endfunction

endpackage

// ----- rtl/texture_wrap_scale_sampler_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texture_wrap_scale_sampler_core
// Nearest-neighbor RGBA texture sampler with translation, floored wrap onto
// the scaled tile and Q8.8 mapping back to the stored texture.
//
//   channel  dir  handshake          payload
//   in_      in   in_valid/in_stall  tws_in_t   (load texel or sample pixel)
//   out_     out  out_valid/out_stall tws_out_t (one beat per sample)
//   cfg_     in   APB, pready high   8 registers at 4*i
//
// One beat enters per cycle while in_stall is low. A sample shows on
// out_valid after the remainder pipeline, one stage per bit of the shifted
// position, then the texel store read and the output register.
// Loads write the store in order with samples and give no beat.
// Reset clears control only; the texel store has no clearing pass.
// A sink stall fills the skid entry; in_stall then holds the whole pipeline.
// ----------------------------------------------------------------------------
module texture_wrap_scale_sampler_core #(
  parameter int MAX_WIDTH  = tws_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = tws_pkg::DEF_MAX_HEIGHT,
  parameter int COORD_BITS = tws_pkg::DEF_COORD_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  tws_pkg::tws_in_t                   in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output tws_pkg::tws_out_t                  out_data,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [tws_pkg::CFG_ADDR_BITS-1:0]  cfg_paddr,
  input  logic [tws_pkg::CFG_DATA_BITS-1:0]  cfg_pwdata,
  output logic [tws_pkg::CFG_DATA_BITS-1:0]  cfg_prdata,
  output logic                               cfg_pready
);
  import tws_pkg::*;

  localparam int LAT      = tws_axis_latency(COORD_BITS);
  localparam int COL_BITS = tws_idx_bits(MAX_WIDTH);
  localparam int ROW_BITS = tws_idx_bits(MAX_HEIGHT);
  localparam logic [31:0] CMASK = (32'd1 << COORD_BITS) - 32'd1;

  tws_cfg_t            cfg;
  tws_in_t             in_m;
  logic                adv;
  logic [COL_BITS-1:0] col;
  logic [ROW_BITS-1:0] row;

  logic                pipe_valid_r [0:LAT-1];
  tws_in_t             pipe_data_r  [0:LAT-1];

  assign in_stall = !adv;

  always_comb begin
    in_m       = in_data;
    in_m.pos_x = in_data.pos_x & CMASK[POS_BITS-1:0];
    in_m.pos_y = in_data.pos_y & CMASK[POS_BITS-1:0];
  end

  tws_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  tws_axis #(
    .MAX_SIZE   (MAX_WIDTH),
    .COORD_BITS (COORD_BITS)
  ) u_axis_x (
    .clk    (clk),
    .en     (adv),
    .pos    (in_m.pos_x),
    .shift  (cfg.shift_x),
    .scaled (cfg.scaled_width),
    .step   (cfg.step_x),
    .size   (cfg.texture_width),
    .idx    (col)
  );

  tws_axis #(
    .MAX_SIZE   (MAX_HEIGHT),
    .COORD_BITS (COORD_BITS)
  ) u_axis_y (
    .clk    (clk),
    .en     (adv),
    .pos    (in_m.pos_y),
    .shift  (cfg.shift_y),
    .scaled (cfg.scaled_height),
    .step   (cfg.step_y),
    .size   (cfg.texture_height),
    .idx    (row)
  );

  // beat delay line matched to the axis pipelines
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) begin
        pipe_valid_r[i] <= 1'b0;
      end
    end else if (adv) begin
      pipe_valid_r[0] <= in_valid;
      for (int i = 1; i < LAT; i++) begin
        pipe_valid_r[i] <= pipe_valid_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pipe_data_r[0] <= in_m;
      for (int i = 1; i < LAT; i++) begin
        pipe_data_r[i] <= pipe_data_r[i-1];
      end
    end
  end

  tws_texmem #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_texmem (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid     (pipe_valid_r[LAT-1]),
    .item      (pipe_data_r[LAT-1]),
    .col       (col),
    .row       (row),
    .adv       (adv),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/tws_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_cfg
// APB register file holding sizes, steps and shifts of the sampler.
// ----------------------------------------------------------------------------
module tws_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [tws_pkg::CFG_ADDR_BITS-1:0]  cfg_paddr,
  input  logic [tws_pkg::CFG_DATA_BITS-1:0]  cfg_pwdata,
  output logic [tws_pkg::CFG_DATA_BITS-1:0]  cfg_prdata,
  output logic                               cfg_pready,
  output tws_pkg::tws_cfg_t                  cfg
);
  import tws_pkg::*;

  tws_cfg_t                cfg_r;
  logic                    wr_en;
  logic [REG_IDX_BITS-1:0] idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign idx        = cfg_paddr[CFG_ADDR_BITS-1:2];
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.texture_width  <= SIZE_BITS'(1);
      cfg_r.texture_height <= SIZE_BITS'(1);
      cfg_r.scaled_width   <= SCALE_BITS'(1);
      cfg_r.scaled_height  <= SCALE_BITS'(1);
      cfg_r.step_x         <= STEP_BITS'(256);
      cfg_r.step_y         <= STEP_BITS'(256);
      cfg_r.shift_x        <= '0;
      cfg_r.shift_y        <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_TEXTURE_WIDTH:  cfg_r.texture_width  <= cfg_pwdata[SIZE_BITS-1:0];
        REG_TEXTURE_HEIGHT: cfg_r.texture_height <= cfg_pwdata[SIZE_BITS-1:0];
        REG_SCALED_WIDTH:   cfg_r.scaled_width   <= cfg_pwdata[SCALE_BITS-1:0];
        REG_SCALED_HEIGHT:  cfg_r.scaled_height  <= cfg_pwdata[SCALE_BITS-1:0];
        REG_STEP_X:         cfg_r.step_x         <= cfg_pwdata[STEP_BITS-1:0];
        REG_STEP_Y:         cfg_r.step_y         <= cfg_pwdata[STEP_BITS-1:0];
        REG_SHIFT_X:        cfg_r.shift_x        <= $signed(cfg_pwdata[SHIFT_BITS-1:0]);
        REG_SHIFT_Y:        cfg_r.shift_y        <= $signed(cfg_pwdata[SHIFT_BITS-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TEXTURE_WIDTH:  cfg_prdata = CFG_DATA_BITS'(cfg_r.texture_width);
      REG_TEXTURE_HEIGHT: cfg_prdata = CFG_DATA_BITS'(cfg_r.texture_height);
      REG_SCALED_WIDTH:   cfg_prdata = CFG_DATA_BITS'(cfg_r.scaled_width);
      REG_SCALED_HEIGHT:  cfg_prdata = CFG_DATA_BITS'(cfg_r.scaled_height);
      REG_STEP_X:         cfg_prdata = CFG_DATA_BITS'(cfg_r.step_x);
      REG_STEP_Y:         cfg_prdata = CFG_DATA_BITS'(cfg_r.step_y);
      REG_SHIFT_X:        cfg_prdata = CFG_DATA_BITS'($unsigned(cfg_r.shift_x));
      REG_SHIFT_Y:        cfg_prdata = CFG_DATA_BITS'($unsigned(cfg_r.shift_y));
      default:            cfg_prdata = '0;
    endcase
  end

endmodule

// ----- rtl/tws_axis.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_axis
// One coordinate axis: shift, floored wrap onto the scaled size by a
// pipelined restoring remainder, Q8.8 map back and clamp to the texture.
// ----------------------------------------------------------------------------
module tws_axis #(
  parameter int MAX_SIZE   = tws_pkg::DEF_MAX_WIDTH,
  parameter int COORD_BITS = tws_pkg::DEF_COORD_BITS
) (
  input  logic                                        clk,
  input  logic                                        en,
  input  logic [tws_pkg::POS_BITS-1:0]                pos,
  input  logic signed [tws_pkg::SHIFT_BITS-1:0]       shift,
  input  logic [tws_pkg::SCALE_BITS-1:0]              scaled,
  input  logic [tws_pkg::STEP_BITS-1:0]               step,
  input  logic [tws_pkg::SIZE_BITS-1:0]               size,
  output logic [tws_pkg::tws_idx_bits(MAX_SIZE)-1:0]  idx
);
  import tws_pkg::*;

  localparam int MAG_BITS = tws_mag_bits(COORD_BITS);
  localparam int PW       = MAG_BITS + 1;
  localparam int DW       = MAG_BITS + SCALE_BITS;
  localparam int IDX_BITS = tws_idx_bits(MAX_SIZE);
  localparam int SRC_BITS = PROD_BITS - FRAC_BITS;

  logic [SCALE_BITS-1:0] sw;
  logic signed [PW-1:0]  p;
  logic [MAG_BITS-1:0]   mag_nxt;

  logic [MAG_BITS-1:0]   rem_r   [0:MAG_BITS];
  logic                  neg_r   [0:MAG_BITS];
  logic [MAG_BITS-1:0]   rem_nxt [1:MAG_BITS];

  logic [DW-1:0]         fin;
  logic [SCALE_BITS-1:0] rem_lo;
  logic [SCALE_BITS-1:0] wrap_nxt;
  logic [SCALE_BITS-1:0] wrap_r;
  logic [PROD_BITS-1:0]  prod_r;
  logic [SRC_BITS-1:0]   src;
  logic [IDX_BITS-1:0]   lim_m1;
  logic [IDX_BITS-1:0]   idx_r;

  assign sw      = (scaled == '0) ? SCALE_BITS'(1) : scaled;
  assign p       = PW'($signed({1'b0, pos})) - PW'(shift);
  assign mag_nxt = p[PW-1] ? MAG_BITS'(-p) : MAG_BITS'(p);

  // one quotient bit per stage, highest first
  always_comb begin
    logic [DW-1:0] dvs;
    logic [DW-1:0] cur;
    for (int i = 0; i < MAG_BITS; i++) begin
      dvs = DW'(sw) << (MAG_BITS - 1 - i);
      cur = DW'(rem_r[i]);
      rem_nxt[i+1] = (cur >= dvs) ? MAG_BITS'(cur - dvs) : rem_r[i];
    end
  end

  assign fin      = DW'(rem_r[MAG_BITS]);
  assign rem_lo   = fin[SCALE_BITS-1:0];
  assign wrap_nxt = (neg_r[MAG_BITS] && rem_lo != '0) ? sw - rem_lo : rem_lo;
  assign src      = prod_r[PROD_BITS-1:FRAC_BITS];

  always_comb begin
    logic [31:0] lim;
    lim = 32'(size);
    if (lim == 32'd0) begin
      lim = 32'd1;
    end
    if (lim > 32'(MAX_SIZE)) begin
      lim = 32'(MAX_SIZE);
    end
    lim_m1 = IDX_BITS'(lim - 32'd1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= mag_nxt;
      neg_r[0] <= p[PW-1];
      for (int i = 0; i < MAG_BITS; i++) begin
        rem_r[i+1] <= rem_nxt[i+1];
        neg_r[i+1] <= neg_r[i];
      end
      wrap_r <= wrap_nxt;
      prod_r <= PROD_BITS'(wrap_r) * PROD_BITS'(step);
      idx_r  <= (src > SRC_BITS'(lim_m1)) ? lim_m1 : IDX_BITS'(src);
    end
  end

  assign idx = idx_r;

endmodule

// ----- rtl/tws_texmem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_texmem
// Texel store with one access per beat, registered read, output register
// and one-entry skid buffer that holds the pipeline while the sink stalls.
// ----------------------------------------------------------------------------
module tws_texmem #(
  parameter int MAX_WIDTH  = tws_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = tws_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          valid,
  input  tws_pkg::tws_in_t                              item,
  input  logic [tws_pkg::tws_idx_bits(MAX_WIDTH)-1:0]   col,
  input  logic [tws_pkg::tws_idx_bits(MAX_HEIGHT)-1:0]  row,
  output logic                                          adv,
  output logic                                          out_valid,
  input  logic                                          out_stall,
  output tws_pkg::tws_out_t                             out_data
);
  import tws_pkg::*;

  localparam int DEPTH     = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_BITS = tws_idx_bits(DEPTH);

  logic [TEXEL_BITS-1:0] mem [0:DEPTH-1];

  logic                  wr_en;
  logic                  in_range;
  logic [ADDR_BITS-1:0]  waddr;
  logic [ADDR_BITS-1:0]  raddr;

  logic                  m_valid_r;
  logic [POS_BITS-1:0]   m_px_r;
  logic [POS_BITS-1:0]   m_py_r;
  logic [TEXEL_BITS-1:0] rdata_r;
  tws_out_t              m_out;

  logic                  out_valid_r;
  tws_out_t              out_r;
  logic                  skid_valid_r;
  tws_out_t              skid_r;
  logic                  take;
  logic                  push;

  assign adv      = !skid_valid_r;
  assign in_range = (32'(item.pos_x) < 32'(MAX_WIDTH)) &&
                    (32'(item.pos_y) < 32'(MAX_HEIGHT));
  assign wr_en    = adv && valid && (item.operation == OP_LOAD) && in_range;
  assign waddr    = ADDR_BITS'(32'(item.pos_y) * 32'(MAX_WIDTH) + 32'(item.pos_x));
  assign raddr    = ADDR_BITS'(32'(row) * 32'(MAX_WIDTH) + 32'(col));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= {item.red_in, item.green_in, item.blue_in, item.alpha_in};
    end
    if (adv) begin
      rdata_r <= mem[raddr];
      m_px_r  <= item.pos_x;
      m_py_r  <= item.pos_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else if (adv) begin
      m_valid_r <= valid && (item.operation == OP_SAMPLE);
    end
  end

  always_comb begin
    m_out.pixel_x   = m_px_r;
    m_out.pixel_y   = m_py_r;
    m_out.red_out   = rdata_r[4*COLOR_BITS-1:3*COLOR_BITS];
    m_out.green_out = rdata_r[3*COLOR_BITS-1:2*COLOR_BITS];
    m_out.blue_out  = rdata_r[2*COLOR_BITS-1:COLOR_BITS];
    m_out.alpha_out = rdata_r[COLOR_BITS-1:0];
  end

  assign take = out_valid_r && !out_stall;
  assign push = adv && m_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (take) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (!out_valid_r || take) begin
      out_valid_r <= push;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (take) begin
        out_r <= skid_r;
      end
    end else if (!out_valid_r || take) begin
      out_r <= m_out;
    end else if (push) begin
      skid_r <= m_out;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- rtl/tws_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_checker
// Port-level checks of the sampler's flow control, bound to the top level.
// ----------------------------------------------------------------------------
module tws_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input tws_pkg::tws_out_t out_data
);
  import tws_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");

  a_stall_has_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no output beat pending");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stall rose without a stalled output beat");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("reset left flow control active");

endmodule

bind texture_wrap_scale_sampler_core tws_checker u_tws_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ----- tb/texture_wrap_scale_sampler_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texture_wrap_scale_sampler_checker
// Passive scoreboard for the texture sampler core. It shadows the register
// writes on the APB port and the texel loads on the input channel. For each
// sample beat it computes the wrapped, scaled and clamped texel and queues
// the pixel. Each output beat is compared field by field with the oldest
// queued pixel. Mismatches are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
module texture_wrap_scale_sampler_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  tws_pkg::tws_in_t                  in_data,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  tws_pkg::tws_out_t                 out_data,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic                              cfg_pready,
  input  logic [tws_pkg::CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [tws_pkg::CFG_DATA_BITS-1:0] cfg_pwdata,
  output int                                fail_count,
  output int                                samples_pending
);
  import tws_pkg::*;

  localparam int STORE_DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;

  tws_cfg_t              cfg_shadow;
  logic [TEXEL_BITS-1:0] texel_mem [STORE_DEPTH];
  tws_out_t              pending_pixels [$];

  // shift, floored wrap onto the scaled tile, Q8.8 map back, clamp
  function automatic int wrap_map_axis(input logic [POS_BITS-1:0] pos,
                                       input logic signed [SHIFT_BITS-1:0] shift,
                                       input logic [SCALE_BITS-1:0] scaled,
                                       input logic [STEP_BITS-1:0] step,
                                       input logic [SIZE_BITS-1:0] size,
                                       input int max_size);
    longint span, shift_val, offset, rem, src, lim;
    span = scaled;
    if (span == 0) span = 1;
    shift_val = shift;
    offset = pos;
    offset = offset - shift_val;
    rem = offset % span;
    if (rem < 0) rem = rem + span;
    src = (rem * step) >> FRAC_BITS;
    lim = size;
    if (lim == 0) lim = 1;
    if (lim > max_size) lim = max_size;
    if (src >= lim) src = lim - 1;
    return int'(src);
  endfunction

  function automatic tws_out_t predict_pixel(input tws_in_t item);
    tws_out_t              pix;
    int                    col, row;
    logic [TEXEL_BITS-1:0] word;
    col = wrap_map_axis(item.pos_x, cfg_shadow.shift_x, cfg_shadow.scaled_width,
                        cfg_shadow.step_x, cfg_shadow.texture_width, DEF_MAX_WIDTH);
    row = wrap_map_axis(item.pos_y, cfg_shadow.shift_y, cfg_shadow.scaled_height,
                        cfg_shadow.step_y, cfg_shadow.texture_height, DEF_MAX_HEIGHT);
    word = texel_mem[row * DEF_MAX_WIDTH + col];
    pix.pixel_x   = item.pos_x;
    pix.pixel_y   = item.pos_y;
    pix.red_out   = word[31:24];
    pix.green_out = word[23:16];
    pix.blue_out  = word[15:8];
    pix.alpha_out = word[7:0];
    return pix;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    tws_out_t want;
    int       addr;
    if (!rst_n) begin
      cfg_shadow = '{texture_width: 7'd1, texture_height: 7'd1,
                     scaled_width: 13'd1, scaled_height: 13'd1,
                     step_x: 16'd256, step_y: 16'd256,
                     shift_x: 12'd0, shift_y: 12'd0};
      pending_pixels.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[CFG_ADDR_BITS-1:2])
          REG_TEXTURE_WIDTH:  cfg_shadow.texture_width  = cfg_pwdata[SIZE_BITS-1:0];
          REG_TEXTURE_HEIGHT: cfg_shadow.texture_height = cfg_pwdata[SIZE_BITS-1:0];
          REG_SCALED_WIDTH:   cfg_shadow.scaled_width   = cfg_pwdata[SCALE_BITS-1:0];
          REG_SCALED_HEIGHT:  cfg_shadow.scaled_height  = cfg_pwdata[SCALE_BITS-1:0];
          REG_STEP_X:         cfg_shadow.step_x         = cfg_pwdata[STEP_BITS-1:0];
          REG_STEP_Y:         cfg_shadow.step_y         = cfg_pwdata[STEP_BITS-1:0];
          REG_SHIFT_X:        cfg_shadow.shift_x        = cfg_pwdata[SHIFT_BITS-1:0];
          REG_SHIFT_Y:        cfg_shadow.shift_y        = cfg_pwdata[SHIFT_BITS-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (pending_pixels.size() == 0) begin
          $display("%0t unexpected output beat: expected none actual %h", $time, out_data);
          fail_count++;
        end else begin
          want = pending_pixels.pop_front();
          check_field("pixel_x", 32'(want.pixel_x), 32'(out_data.pixel_x));
          check_field("pixel_y", 32'(want.pixel_y), 32'(out_data.pixel_y));
          check_field("red_out", 32'(want.red_out), 32'(out_data.red_out));
          check_field("green_out", 32'(want.green_out), 32'(out_data.green_out));
          check_field("blue_out", 32'(want.blue_out), 32'(out_data.blue_out));
          check_field("alpha_out", 32'(want.alpha_out), 32'(out_data.alpha_out));
        end
      end
      if (in_valid && !in_stall) begin
        if (in_data.operation == OP_LOAD) begin
          if (in_data.pos_x < DEF_MAX_WIDTH && in_data.pos_y < DEF_MAX_HEIGHT) begin
            addr = int'(in_data.pos_y) * DEF_MAX_WIDTH + int'(in_data.pos_x);
            texel_mem[addr] = {in_data.red_in, in_data.green_in,
                               in_data.blue_in, in_data.alpha_in};
          end
        end else begin
          pending_pixels = {pending_pixels, predict_pixel(in_data)};
        end
      end
    end
    samples_pending = pending_pixels.size();
  end

endmodule

// ----- tb/texture_wrap_scale_sampler_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texture_wrap_scale_sampler_core_tb
// Stimulus and verdict for the texture sampler core. A directed run at the
// reset settings is followed by phases of register settings, extremes first,
// then random ones. Each phase loads each reachable texel not yet written, then
// mixes samples, texel rewrites and ignored out-of-range loads, with random
// gaps on both channels and one long output hold-off. Checking is done by
// the scoreboard instance.
// ----------------------------------------------------------------------------
module texture_wrap_scale_sampler_core_tb;
  import tws_pkg::*;

  localparam int ITEM_TARGET      = 1350;
  localparam int DRAIN_CYCLES     = tws_axis_latency(DEF_COORD_BITS) + 2 + 8;
  localparam int IDLE_LIMIT       = 20000;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int STORE_DEPTH      = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  tws_in_t                  in_data;
  logic                     out_valid;
  logic                     out_stall;
  tws_out_t                 out_data;
  logic                     cfg_psel;
  logic                     cfg_penable;
  logic                     cfg_pwrite;
  logic [CFG_ADDR_BITS-1:0] cfg_paddr;
  logic [CFG_DATA_BITS-1:0] cfg_pwdata;
  logic [CFG_DATA_BITS-1:0] cfg_prdata;
  logic                     cfg_pready;

  int fail_count;
  int samples_pending;
  int idle_cycles = 0;
  int random_items = 0;

  bit sender_steady  = 1'b0;
  bit sink_steady    = 1'b0;
  bit long_hold_req  = 1'b0;
  bit long_hold_done = 1'b0;
  bit texel_loaded [STORE_DEPTH];

  always #1 clk = ~clk;

  texture_wrap_scale_sampler_core u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  texture_wrap_scale_sampler_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_pready      (cfg_pready),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .fail_count      (fail_count),
    .samples_pending (samples_pending)
  );

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int eff_size(input logic [SIZE_BITS-1:0] raw, input int limit);
    if (raw == 0) return 1;
    if (raw > limit) return limit;
    return raw;
  endfunction

  function automatic logic [SIZE_BITS-1:0] pick_tex_size(input bit wide_ok);
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (wide_ok && r < 14) return 7'($urandom_range(65, 127));
    if (wide_ok && r < 20) return 7'd64;
    if (wide_ok && r < 32) return 7'($urandom_range(9, 63));
    return 7'($urandom_range(1, 8));
  endfunction

  function automatic logic [SCALE_BITS-1:0] pick_scaled();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return 13'($urandom_range(4097, 8191));
    if (r < 24) return 13'd1;
    if (r < 30) return 13'd4096;
    if (r < 70) return 13'($urandom_range(2, 64));
    return 13'($urandom_range(65, 4095));
  endfunction

  function automatic logic [STEP_BITS-1:0] pick_step(input int size_eff,
                                                     input logic [SCALE_BITS-1:0] scaled);
    int r, span, fit;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 14) return 16'hFFFF;
    if (r < 20) return 16'd1;
    if (r < 60) begin
      span = (scaled == 0) ? 1 : int'(scaled);
      fit = size_eff * 256 / span + int'($urandom_range(0, 64)) - 32;
      if (fit < 0) fit = 0;
      if (fit > 65535) fit = 65535;
      return 16'(fit);
    end
    return 16'($urandom());
  endfunction

  function automatic logic signed [SHIFT_BITS-1:0] pick_shift();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 12'h800;
    if (r < 20) return 12'h7FF;
    return 12'($urandom());
  endfunction

  function automatic tws_cfg_t pick_config();
    tws_cfg_t c;
    int       tw_eff, th_eff;
    c.texture_width  = pick_tex_size(1'b1);
    tw_eff           = eff_size(c.texture_width, DEF_MAX_WIDTH);
    c.texture_height = pick_tex_size(tw_eff <= 8);
    th_eff           = eff_size(c.texture_height, DEF_MAX_HEIGHT);
    c.scaled_width   = pick_scaled();
    c.scaled_height  = pick_scaled();
    c.step_x         = pick_step(tw_eff, c.scaled_width);
    c.step_y         = pick_step(th_eff, c.scaled_height);
    c.shift_x        = pick_shift();
    c.shift_y        = pick_shift();
    return c;
  endfunction

  // screen coordinate, often close to the wrap boundaries
  function automatic logic [POS_BITS-1:0] pick_coord(input logic signed [SHIFT_BITS-1:0] shift,
                                                     input logic [SCALE_BITS-1:0] scaled);
    int span, near;
    if ($urandom_range(0, 99) < 55) return 12'($urandom());
    span = (scaled == 0) ? 1 : int'(scaled);
    near = int'($urandom_range(0, 2 * span + 2)) - span / 2;
    return 12'(int'(shift) + near);
  endfunction

  function automatic tws_in_t make_item(input logic op, input int x, input int y,
                                        input logic [TEXEL_BITS-1:0] rgba);
    tws_in_t item;
    item.operation = op;
    item.pos_x     = 12'(x);
    item.pos_y     = 12'(y);
    item.red_in    = rgba[31:24];
    item.green_in  = rgba[23:16];
    item.blue_in   = rgba[15:8];
    item.alpha_in  = rgba[7:0];
    return item;
  endfunction

  // called and returns at a falling edge; valid stays high for a following beat
  task automatic send_beat(input tws_in_t item);
    int gap;
    gap = sender_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic load_texel(input int x, input int y, input logic [TEXEL_BITS-1:0] rgba);
    send_beat(make_item(OP_LOAD, x, y, rgba));
    if (x < DEF_MAX_WIDTH && y < DEF_MAX_HEIGHT) texel_loaded[y * DEF_MAX_WIDTH + x] = 1'b1;
  endtask

  task automatic sample_at(input int x, input int y);
    send_beat(make_item(OP_SAMPLE, x, y, $urandom()));
  endtask

  task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  // drop valid, wait for every pixel, then let the pipe run dry
  task automatic settle();
    in_valid <= 1'b0;
    while (samples_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(input tws_cfg_t c, input int n_items);
    int tw, th, r, done;
    write_reg(REG_TEXTURE_WIDTH, 32'(c.texture_width));
    write_reg(REG_TEXTURE_HEIGHT, 32'(c.texture_height));
    write_reg(REG_SCALED_WIDTH, 32'(c.scaled_width));
    write_reg(REG_SCALED_HEIGHT, 32'(c.scaled_height));
    write_reg(REG_STEP_X, 32'(c.step_x));
    write_reg(REG_STEP_Y, 32'(c.step_y));
    write_reg(REG_SHIFT_X, {20'd0, c.shift_x});
    write_reg(REG_SHIFT_Y, {20'd0, c.shift_y});
    tw = eff_size(c.texture_width, DEF_MAX_WIDTH);
    th = eff_size(c.texture_height, DEF_MAX_HEIGHT);
    // every reachable texel gets written before any sample
    for (int y = 0; y < th; y++) begin
      for (int x = 0; x < tw; x++) begin
        if (!texel_loaded[y * DEF_MAX_WIDTH + x]) begin
          load_texel(x, y, $urandom());
          random_items++;
        end
      end
    end
    done = 0;
    while (done < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 72) begin
        sample_at(pick_coord(c.shift_x, c.scaled_width), pick_coord(c.shift_y, c.scaled_height));
        done++;
      end else if (r < 86) begin
        load_texel($urandom_range(0, tw - 1), $urandom_range(0, th - 1), $urandom());
        done++;
      end else if (r < 92) begin
        load_texel($urandom_range(0, DEF_MAX_WIDTH - 1), $urandom_range(0, DEF_MAX_HEIGHT - 1),
                   $urandom());
        done++;
      end else if (r < 96) begin
        load_texel($urandom_range(DEF_MAX_WIDTH, 4095), $urandom_range(0, 4095), $urandom());
        done++;
      end else begin
        load_texel($urandom_range(0, 4095), $urandom_range(DEF_MAX_HEIGHT, 4095), $urandom());
        done++;
      end
    end
    random_items += done;
    settle();
  endtask

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: random stalls, steady stretches, one long hold-off once samples flow
  initial begin
    out_stall = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (long_hold_req && !long_hold_done && samples_pending != 0) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        long_hold_done = 1'b1;
      end else if (sink_steady) begin
        out_stall <= 1'b0;
        repeat (20) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
        out_stall <= 1'b1;
        repeat (pick_gap() + 1) @(negedge clk);
      end
    end
  end

  initial begin
    int phase;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: every sample lands on texel (0,0)
    load_texel(0, 0, 32'hFFFF_FFFF);
    load_texel(DEF_MAX_WIDTH - 1, DEF_MAX_HEIGHT - 1, 32'h0);
    load_texel(DEF_MAX_WIDTH - 1, 0, $urandom());
    load_texel(0, DEF_MAX_HEIGHT - 1, $urandom());
    load_texel(DEF_MAX_WIDTH, 0, $urandom());
    load_texel(0, DEF_MAX_HEIGHT, $urandom());
    load_texel(4095, 4095, $urandom());
    sample_at(0, 0);
    sample_at(4095, 4095);
    sample_at(4095, 0);
    sample_at(0, 4095);
    load_texel(0, 0, 32'h0);
    sample_at(2048, 2048);
    load_texel(0, 0, 32'hA55A_C33C);
    sample_at(1, 4094);
    settle();

    // register extremes: zero and oversize sizes, zero and full steps, shift limits
    run_phase('{texture_width: 7'd64, texture_height: 7'd2, scaled_width: 13'd8191,
                scaled_height: 13'd0, step_x: 16'hFFFF, step_y: 16'd0,
                shift_x: 12'h800, shift_y: 12'h7FF}, 10);
    run_phase('{texture_width: 7'd0, texture_height: 7'd127, scaled_width: 13'd0,
                scaled_height: 13'd8191, step_x: 16'd0, step_y: 16'hFFFF,
                shift_x: 12'h7FF, shift_y: 12'h800}, 10);
    run_phase('{texture_width: 7'd100, texture_height: 7'd1, scaled_width: 13'd4096,
                scaled_height: 13'd4096, step_x: 16'd1, step_y: 16'd256,
                shift_x: 12'h000, shift_y: 12'hFFF}, 10);
    run_phase('{texture_width: 7'd3, texture_height: 7'd64, scaled_width: 13'd1,
                scaled_height: 13'd64, step_x: 16'd256, step_y: 16'd256,
                shift_x: 12'h001, shift_y: 12'h005}, 10);

    phase = 0;
    while (random_items < ITEM_TARGET) begin
      sink_steady = ($urandom_range(0, 4) == 0);
      if (phase == 3) begin
        sender_steady = 1'b1;
        long_hold_req = 1'b1;
        run_phase(pick_config(), 150);
      end else begin
        sender_steady = ($urandom_range(0, 4) == 0);
        run_phase(pick_config(), $urandom_range(30, 70));
      end
      phase++;
    end

    settle();
    if (fail_count == 0 && samples_pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/tws_pkg.sv
rtl/tws_cfg.sv
rtl/tws_axis.sv
rtl/tws_texmem.sv
rtl/texture_wrap_scale_sampler_core.sv
rtl/tws_checker.sv
tb/texture_wrap_scale_sampler_checker.sv
tb/texture_wrap_scale_sampler_core_tb.sv
